// File: rtl/jesf_pkg.sv
// Package: shared types, codes and constants of the joint effort safety filter.
package jesf_pkg;
  localparam int JOINTS = 32;
  localparam int JIDX_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam logic [16:0] IDLE_MAX = 17'h1FFFF;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_TILT  = 3'd1,
    CMD_STATE = 3'd2,
    CMD_EFF   = 3'd3,
    CMD_LIMIT = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    R_NORMAL  = 3'd0,
    R_CLAMP   = 3'd1,
    R_LIMIT   = 3'd2,
    R_TIMEOUT = 3'd3,
    R_TILT    = 3'd4,
    R_SPEED   = 3'd5
  } reason_e;

  typedef enum logic [2:0] {
    REG_ENABLE  = 3'd0,
    REG_EMAX    = 3'd1,
    REG_MARGIN  = 3'd2,
    REG_TIMEOUT = 3'd3,
    REG_ROLL    = 3'd4,
    REG_PITCH   = 3'd5,
    REG_SPD_DEF = 3'd6,
    REG_SPD_ANK = 3'd7
  } reg_e;

  typedef struct packed {
    logic        safety_enable;
    logic [14:0] eff_limit;
    logic [14:0] limit_margin;
    logic [15:0] timeout_ticks;
    logic [14:0] roll_limit;
    logic [14:0] pitch_limit;
    logic [14:0] speed_limit_default;
    logic [14:0] speed_limit_ankle;
  } cfg_t;

  typedef struct packed {
    logic [4:0]         joint_out;
    logic signed [15:0] effort_out;
    logic               stop_all;
    reason_e            reason;
    logic               reason_changed;
    logic               last_out;
  } res_t;
endpackage

// File: rtl/jesf_if.sv
// Interfaces: input item, result item and configuration write channels.
interface jesf_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic [4:0]         joint;
  logic signed [15:0] effort_in;
  logic signed [15:0] position;
  logic signed [15:0] speed;
  logic signed [15:0] roll;
  logic signed [15:0] pitch;
  logic signed [15:0] bound_lo;
  logic signed [15:0] bound_hi;
  logic               limit_present;
  logic               ankle_joint;
  logic               last;
  modport source (output valid, command, joint, effort_in, position, speed, roll, pitch,
                  bound_lo, bound_hi, limit_present, ankle_joint, last, input ready);
  modport sink (input valid, command, joint, effort_in, position, speed, roll, pitch,
                bound_lo, bound_hi, limit_present, ankle_joint, last, output ready);
endinterface

interface jesf_out_if;
  logic               valid;
  logic               ready;
  logic [4:0]         joint_out;
  logic signed [15:0] effort_out;
  logic               stop_all;
  logic [2:0]         reason;
  logic               reason_changed;
  logic               last_out;
  modport source (output valid, joint_out, effort_out, stop_all, reason, reason_changed,
                  last_out, input ready);
  modport sink (input valid, joint_out, effort_out, stop_all, reason, reason_changed,
                last_out, output ready);
endinterface

interface jesf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/jesf_cfg_regs.sv
// Configuration register file.
module jesf_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [2:0]         wr_index_i,
  input  logic [15:0]        wr_data_i,
  output jesf_pkg::cfg_t     cfg_o
);
  import jesf_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (reg_e'(wr_index_i))
        REG_ENABLE:  cfg_d.safety_enable       = wr_data_i[0];
        REG_EMAX:    cfg_d.eff_limit           = wr_data_i[14:0];
        REG_MARGIN:  cfg_d.limit_margin        = wr_data_i[14:0];
        REG_TIMEOUT: cfg_d.timeout_ticks       = wr_data_i;
        REG_ROLL:    cfg_d.roll_limit          = wr_data_i[14:0];
        REG_PITCH:   cfg_d.pitch_limit         = wr_data_i[14:0];
        REG_SPD_DEF: cfg_d.speed_limit_default = wr_data_i[14:0];
        REG_SPD_ANK: cfg_d.speed_limit_ankle   = wr_data_i[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.safety_enable       <= 1'b1;
      cfg_q.eff_limit           <= 15'd2048;
      cfg_q.limit_margin        <= 15'd205;
      cfg_q.timeout_ticks       <= 16'd30;
      cfg_q.roll_limit          <= 15'd2458;
      cfg_q.pitch_limit         <= 15'd2458;
      cfg_q.speed_limit_default <= 15'd8192;
      cfg_q.speed_limit_ankle   <= 15'd12288;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
endmodule

// File: rtl/jesf_core.sv
// Filter core: joint tables, message state and one-pass effort filtering.
module jesf_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  jesf_pkg::cfg_t     cfg_i,
  input  logic               acc_i,
  input  logic [2:0]         command_i,
  input  logic [4:0]         joint_i,
  input  logic signed [15:0] effort_i,
  input  logic signed [15:0] position_i,
  input  logic signed [15:0] speed_i,
  input  logic signed [15:0] roll_i,
  input  logic signed [15:0] pitch_i,
  input  logic signed [15:0] bound_lo_i,
  input  logic signed [15:0] bound_hi_i,
  input  logic               limit_present_i,
  input  logic               ankle_joint_i,
  input  logic               last_i,
  output logic               res_valid_o,
  output jesf_pkg::res_t     res_o
);
  import jesf_pkg::*;

  logic signed [15:0] lower_q [JOINTS];
  logic signed [15:0] upper_q [JOINTS];
  logic signed [15:0] pos_q   [JOINTS];
  logic [JOINTS-1:0]  limit_valid_q, limit_valid_d;
  logic [JOINTS-1:0]  ankle_q, ankle_d;
  logic [JOINTS-1:0]  pos_valid_q, pos_valid_d;
  logic [JOINTS-1:0]  overspeed_q, overspeed_d;
  logic               tilt_q, tilt_d;
  logic [16:0]        idle_q, idle_d;
  logic               state_open_q, state_open_d;
  logic               cmd_open_q, cmd_open_d;
  logic               clamp_hit_q, clamp_hit_d;
  logic               limit_hit_q, limit_hit_d;
  reason_e            prev_q, prev_d;

  logic               jok;
  logic [JIDX_W-1:0]  jidx;
  logic [JOINTS-1:0]  jbit;
  logic [16:0]        abs_r, abs_p, abs_s;
  logic [14:0]        spd_lim;
  logic signed [15:0] ld_lo, ld_hi;
  logic signed [16:0] e, m;
  logic signed [17:0] lo, hi, slo, shi, pos;
  logic               hit;
  reason_e            rsn;

  assign jok  = {1'b0, joint_i} < 6'(JOINTS);
  assign jidx = JIDX_W'(joint_i);
  assign jbit = jok ? (JOINTS'(1) << jidx) : '0;

  assign abs_r = roll_i[15]  ? 17'(-$signed({roll_i[15], roll_i}))   : {1'b0, roll_i};
  assign abs_p = pitch_i[15] ? 17'(-$signed({pitch_i[15], pitch_i})) : {1'b0, pitch_i};
  assign abs_s = speed_i[15] ? 17'(-$signed({speed_i[15], speed_i})) : {1'b0, speed_i};
  assign spd_lim = ankle_q[jidx] ? cfg_i.speed_limit_ankle : cfg_i.speed_limit_default;

  assign ld_lo = (bound_lo_i > bound_hi_i) ? bound_hi_i : bound_lo_i;
  assign ld_hi = (bound_lo_i > bound_hi_i) ? bound_lo_i : bound_hi_i;

  always_comb begin
    limit_valid_d = limit_valid_q;
    ankle_d       = ankle_q;
    pos_valid_d   = pos_valid_q;
    overspeed_d   = overspeed_q;
    tilt_d        = tilt_q;
    idle_d        = idle_q;
    state_open_d  = state_open_q;
    cmd_open_d    = cmd_open_q;
    clamp_hit_d   = clamp_hit_q;
    limit_hit_d   = limit_hit_q;
    prev_d        = prev_q;
    res_valid_o   = 1'b0;
    res_o         = '0;
    e   = 17'(effort_i);
    m   = {2'b00, cfg_i.eff_limit};
    lo  = 18'(lower_q[jidx]);
    hi  = 18'(upper_q[jidx]);
    pos = 18'(pos_q[jidx]);
    slo = lo + 18'({3'b000, cfg_i.limit_margin});
    shi = hi - 18'({3'b000, cfg_i.limit_margin});
    hit = 1'b0;
    rsn = R_NORMAL;
    case (cmd_e'(command_i))
      CMD_TICK: begin
        if (idle_q != IDLE_MAX) idle_d = idle_q + 17'd1;
        if (cfg_i.safety_enable && (cfg_i.timeout_ticks != '0) &&
            (idle_d > {1'b0, cfg_i.timeout_ticks})) begin
          res_valid_o          = 1'b1;
          res_o.stop_all       = 1'b1;
          res_o.reason         = R_TIMEOUT;
          res_o.reason_changed = prev_q != R_TIMEOUT;
          res_o.last_out       = 1'b1;
          prev_d               = R_TIMEOUT;
        end
      end
      CMD_TILT: begin
        tilt_d = ((cfg_i.roll_limit != '0) && (abs_r > {2'b00, cfg_i.roll_limit})) ||
                 ((cfg_i.pitch_limit != '0) && (abs_p > {2'b00, cfg_i.pitch_limit}));
      end
      CMD_STATE: begin
        if (!state_open_q) begin
          pos_valid_d = '0;
          overspeed_d = '0;
        end
        state_open_d = !last_i;
        pos_valid_d  = pos_valid_d | jbit;
        if ((spd_lim != '0) && (abs_s > {2'b00, spd_lim})) overspeed_d = overspeed_d | jbit;
        else overspeed_d = overspeed_d & ~jbit;
      end
      CMD_LIMIT: begin
        if (limit_present_i) limit_valid_d = limit_valid_q | jbit;
        else limit_valid_d = limit_valid_q & ~jbit;
        if (ankle_joint_i) ankle_d = ankle_q | jbit;
        else ankle_d = ankle_q & ~jbit;
      end
      CMD_EFF: begin
        idle_d = '0;
        if (!cmd_open_q) begin
          clamp_hit_d = 1'b0;
          limit_hit_d = 1'b0;
        end
        cmd_open_d = !last_i;
        if (cfg_i.safety_enable) begin
          if (m != '0) begin
            if (e > m) begin
              e = m;
              clamp_hit_d = 1'b1;
            end else if (e < -m) begin
              e = -m;
              clamp_hit_d = 1'b1;
            end
          end
          if (jok && limit_valid_q[jidx] && pos_valid_q[jidx]) begin
            // Crossed soft limits collapse to the floored midpoint
            if (slo > shi) begin
              slo = (lo + hi) >>> 1;
              shi = slo;
            end
            if (pos <= slo && e < 0) begin
              e = '0;
              hit = 1'b1;
            end
            if (pos >= shi && e > 0) begin
              e = '0;
              hit = 1'b1;
            end
            if ((pos < lo || pos > hi) && e != 0) begin
              e = '0;
              hit = 1'b1;
            end
            if (hit) limit_hit_d = 1'b1;
          end
          if (tilt_q) begin
            rsn = R_TILT;
            e = '0;
          end else if (overspeed_q != '0) begin
            rsn = R_SPEED;
            e = '0;
          end else if (limit_hit_d) begin
            rsn = R_LIMIT;
          end else if (clamp_hit_d) begin
            rsn = R_CLAMP;
          end
        end
        res_valid_o      = 1'b1;
        res_o.joint_out  = joint_i;
        res_o.effort_out = 16'(e);
        res_o.reason     = rsn;
        res_o.last_out   = last_i;
        if (last_i) begin
          res_o.reason_changed = prev_q != rsn;
          prev_d               = rsn;
        end
      end
      default: ;
    endcase
    if (!acc_i) res_valid_o = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (acc_i && jok) begin
      if (cmd_e'(command_i) == CMD_STATE) pos_q[jidx] <= position_i;
      if (cmd_e'(command_i) == CMD_LIMIT && limit_present_i) begin
        lower_q[jidx] <= ld_lo;
        upper_q[jidx] <= ld_hi;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_valid_q <= '0;
      ankle_q       <= '0;
      pos_valid_q   <= '0;
      overspeed_q   <= '0;
      tilt_q        <= 1'b0;
      idle_q        <= '0;
      state_open_q  <= 1'b0;
      cmd_open_q    <= 1'b0;
      clamp_hit_q   <= 1'b0;
      limit_hit_q   <= 1'b0;
      prev_q        <= R_NORMAL;
    end else if (acc_i) begin
      limit_valid_q <= limit_valid_d;
      ankle_q       <= ankle_d;
      pos_valid_q   <= pos_valid_d;
      overspeed_q   <= overspeed_d;
      tilt_q        <= tilt_d;
      idle_q        <= idle_d;
      state_open_q  <= state_open_d;
      cmd_open_q    <= cmd_open_d;
      clamp_hit_q   <= clamp_hit_d;
      limit_hit_q   <= limit_hit_d;
      prev_q        <= prev_d;
    end
  end
endmodule

// File: rtl/jesf_skid.sv
// Result register with a skid stage so input acceptance survives an output stall.
module jesf_skid (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  jesf_pkg::res_t data_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output jesf_pkg::res_t data_o
);
  import jesf_pkg::*;

  logic out_valid_q, skid_valid_q;
  res_t out_q, skid_q;
  logic free;

  assign free       = !out_valid_q || out_ready_i;
  assign in_ready_o = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (free) begin
      // Drain skid first; no push can arrive while it is full
      out_valid_q  <= skid_valid_q || push_i;
      skid_valid_q <= 1'b0;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free) begin
      out_q <= skid_valid_q ? skid_q : data_i;
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_o      = out_q;
endmodule

// File: rtl/joint_effort_safety_filter.sv
// Top level of the joint effort safety filter.
// Accepts one item per cycle while the skid register is empty; the result of an item
// that yields one is registered. All filtering is a single combinational pass from the
// accepted item and the joint tables (flip-flop arrays read at the item's joint) into
// the result register, so the rate is one item per clock as long as results are taken;
// a two-deep output buffer takes one more item while the output stalls. Configuration
// writes take effect on the next cycle and are always accepted.
module joint_effort_safety_filter (
  input  logic       clk_i,
  input  logic       rst_ni,
  jesf_in_if.sink    in_i,
  jesf_out_if.source out_o,
  jesf_cfg_if.sink   cfg_i
);
  import jesf_pkg::*;

  cfg_t cfg;
  res_t res, res_out;
  logic res_valid, acc, in_ready;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;
  assign acc         = in_i.valid && in_ready;

  jesf_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  jesf_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .acc_i           (acc),
    .command_i       (in_i.command),
    .joint_i         (in_i.joint),
    .effort_i        (in_i.effort_in),
    .position_i      (in_i.position),
    .speed_i         (in_i.speed),
    .roll_i          (in_i.roll),
    .pitch_i         (in_i.pitch),
    .bound_lo_i      (in_i.bound_lo),
    .bound_hi_i      (in_i.bound_hi),
    .limit_present_i (in_i.limit_present),
    .ankle_joint_i   (in_i.ankle_joint),
    .last_i          (in_i.last),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  jesf_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .data_i      (res),
    .in_ready_o  (in_ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .data_o      (res_out)
  );

  assign out_o.joint_out      = res_out.joint_out;
  assign out_o.effort_out     = res_out.effort_out;
  assign out_o.stop_all       = res_out.stop_all;
  assign out_o.reason         = res_out.reason;
  assign out_o.reason_changed = res_out.reason_changed;
  assign out_o.last_out       = res_out.last_out;
endmodule
